// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands, clocked on clk and quiet while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cond must never hold at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/cstr_pkg.sv =====
// ---------------------------------------------------------------------------
// cstr_pkg
// Types, codes and character helpers shared by the comment stripper modules.
// ---------------------------------------------------------------------------
package cstr_pkg;

  localparam int MAX_SPLICES_DEF = 8;
  localparam int LINE_BITS_DEF   = 20;
  localparam int SPL_W           = 4;   // holds a splice count up to 15
  localparam int REM_W           = 5;   // results per job, at most 4 + 2*8 by default
  localparam int NSLOT           = 4;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = 2;
  localparam int OUT_LINE_W      = 20;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_US    = 8'h5F;

  // warning codes
  localparam logic [3:0] W_NL_STR     = 4'd1;
  localparam logic [3:0] W_NL_CHR     = 4'd2;
  localparam logic [3:0] W_END_STR    = 4'd3;
  localparam logic [3:0] W_END_CHR    = 4'd4;
  localparam logic [3:0] W_NESTED     = 4'd5;
  localparam logic [3:0] W_STRAY      = 4'd6;
  localparam logic [3:0] W_UNTERM     = 4'd7;
  localparam logic [3:0] W_SEP_BEFORE = 4'd8;
  localparam logic [3:0] W_SEP_END    = 4'd9;
  localparam logic [3:0] W_SEP_AFTER  = 4'd10;
  localparam logic [3:0] W_BIN_DIGIT  = 4'd11;

  // configuration register indexes
  localparam logic [2:0] REG_OUTPUT_COMMENTS = 3'd0;
  localparam logic [2:0] REG_KEEP_NEWLINES   = 3'd1;
  localparam logic [2:0] REG_STRING_FILL     = 3'd2;
  localparam logic [2:0] REG_CHAR_FILL       = 3'd3;
  localparam logic [2:0] REG_LINE_COMMENTS   = 3'd4;
  localparam logic [2:0] REG_BINARY_PREFIX   = 3'd5;
  localparam logic [2:0] REG_WARN_NESTING    = 3'd6;

  typedef enum logic [1:0] {R_DEC, R_OCT, R_HEX, R_BIN} radix_t;

  // how a run of backslash-newline pairs is written back
  typedef enum logic [1:0] {PM_NONE, PM_BOTH, PM_NL} pair_mode_t;

  typedef struct packed {
    logic       output_comments;
    logic       keep_comment_newlines;
    logic [7:0] string_fill;
    logic [7:0] char_fill;
    logic       line_comments_on;
    logic       binary_prefix_on;
    logic       warn_nesting;
  } cfg_t;

  typedef struct packed {
    logic       is_warn;
    logic [7:0] val;      // byte, or warning code in the low nibble
  } slot_t;

  typedef slot_t [NSLOT-1:0] slot_vec_t;

  // one input item's worth of results, expanded by the back end
  typedef struct packed {
    slot_vec_t               slots;
    logic [2:0]              nslot;
    logic                    ppos;   // slots written before the pair run
    logic [SPL_W-1:0]        pcnt;
    pair_mode_t              pm;
    logic [OUT_LINE_W-1:0]   wline;
  } job_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic valid_digit(input radix_t r, input logic [7:0] c);
    logic ok;
    case (r)
      R_OCT:   ok = (c >= 8'h30) && (c <= 8'h37);
      R_HEX:   ok = is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
                    ((c >= 8'h41) && (c <= 8'h46));
      R_BIN:   ok = (c == 8'h30) || (c == 8'h31);
      default: ok = is_dig(c);
    endcase
    return ok;
  endfunction

endpackage

// ===== design/c_comment_stripper.sv =====
// Path: a result goes from its source byte transfer through the job queue, the
// back end's current-job register and the output register.
// Throughput: one source byte per cycle in while the job queue has room, one result
// per cycle out while m_tready allows; an item with many results (splice write-back,
// up to 20 by default) holds the back end until all are out. Reset: rst (synchronous)
// clears lexer state, empties the job queue and the output register, and loads the configuration register defaults.
// ---------------------------------------------------------------------------
// c_comment_stripper
// C comment stripping lexer: code or comment bytes out, plus warnings.
// ---------------------------------------------------------------------------
module c_comment_stripper #(
  parameter int MAX_SPLICES = cstr_pkg::MAX_SPLICES_DEF,
  parameter int LINE_BITS   = cstr_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] src_byte
  input  logic        s_tlast,   // is_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [12:9] warning,
                                 // [32:13] line_number, [39:33] zero
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);
  import cstr_pkg::*;

  cfg_t                  cfg;
  logic                  q_full, q_empty, q_push, q_pop;
  job_t                  q_din, q_dout;
  logic [7:0]            o_byte;
  logic                  o_bvalid;
  logic [3:0]            o_warn;
  logic [OUT_LINE_W-1:0] o_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_comments       <= 1'b0;
      cfg.keep_comment_newlines <= 1'b0;
      cfg.string_fill           <= '0;
      cfg.char_fill             <= '0;
      cfg.line_comments_on      <= 1'b1;
      cfg.binary_prefix_on      <= 1'b0;
      cfg.warn_nesting          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OUTPUT_COMMENTS: cfg.output_comments       <= cfg_data[0];
        REG_KEEP_NEWLINES:   cfg.keep_comment_newlines <= cfg_data[0];
        REG_STRING_FILL:     cfg.string_fill           <= cfg_data;
        REG_CHAR_FILL:       cfg.char_fill             <= cfg_data;
        REG_LINE_COMMENTS:   cfg.line_comments_on      <= cfg_data[0];
        REG_BINARY_PREFIX:   cfg.binary_prefix_on      <= cfg_data[0];
        REG_WARN_NESTING:    cfg.warn_nesting          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cstr_front #(
    .MAX_SPLICES(MAX_SPLICES),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_byte (s_tdata),
    .in_end  (s_tlast),
    .in_ready(s_tready),
    .q_full  (q_full),
    .push    (q_push),
    .job     (q_din)
  );

  cstr_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .full (q_full),
    .empty(q_empty)
  );

  cstr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_dout),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (o_byte),
    .out_bvalid(o_bvalid),
    .out_warn  (o_warn),
    .out_line  (o_line),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'd0, o_line, o_warn, o_bvalid, o_byte};

endmodule

// ===== design/cstr_front.sv =====
// ---------------------------------------------------------------------------
// cstr_front
// Lexer front end: classifies one source byte per cycle while the job queue
// has room, and queues the results it causes as a compact job.
// ---------------------------------------------------------------------------
module cstr_front #(
  parameter int MAX_SPLICES = cstr_pkg::MAX_SPLICES_DEF,
  parameter int LINE_BITS   = cstr_pkg::LINE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cstr_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  output logic            in_ready,
  input  logic            q_full,
  output logic            push,
  output cstr_pkg::job_t  job
);
  import cstr_pkg::*;

  typedef enum logic [3:0] {
    M_CODE, M_CODE_STAR, M_SLASH, M_CCOM, M_CCOM_SLASH, M_STAR, M_LCOM,
    M_IDENT, M_DOT, M_ZERO, M_NUM, M_NUM_SEP, M_Q_BODY, M_Q_ESC, M_Q_BSL
  } mode_t;

  localparam logic [LINE_BITS-1:0] LTOP    = {LINE_BITS{1'b1}};
  localparam logic [SPL_W-1:0]     SPL_MAX = SPL_W'(MAX_SPLICES);

  mode_t                 mode, mode_next;
  logic [7:0]            held, held_next;
  logic [SPL_W-1:0]      splices, splices_next;
  logic [7:0]            prev, prev_next;
  logic [LINE_BITS-1:0]  line, line_next;
  logic [LINE_BITS-1:0]  nest_line, nest_line_next;
  logic [LINE_BITS-1:0]  stray_line, stray_line_next;
  radix_t                radix, radix_next;
  logic [7:0]            last_dig, last_dig_next;

  logic                  take;
  logic                  go;
  logic [7:0]            ch;
  logic [7:0]            fb;
  logic [2:0]            n;
  slot_vec_t             sl;
  logic                  ppos;
  logic [SPL_W-1:0]      pcnt;
  pair_mode_t            pm;
  logic [OUT_LINE_W-1:0] wl;

  function automatic void put(inout logic [2:0] cnt, inout slot_vec_t v,
                              input logic w, input logic [7:0] b);
    if (cnt < 3'(NSLOT)) begin
      v[cnt[1:0]].is_warn = w;
      v[cnt[1:0]].val     = b;
      cnt = cnt + 3'd1;
    end
  endfunction

  function automatic logic [LINE_BITS-1:0] bump(input logic [LINE_BITS-1:0] l,
                                                input logic [7:0] c);
    return ((c == CH_NL) && (l != LTOP)) ? l + LINE_BITS'(1) : l;
  endfunction

  function automatic logic com_keep(input cfg_t k, input logic [7:0] b);
    return k.output_comments || (k.keep_comment_newlines && (b == CH_NL));
  endfunction

  function automatic pair_mode_t com_pm(input cfg_t k);
    pair_mode_t r;
    if (k.output_comments) r = PM_BOTH;
    else if (k.keep_comment_newlines) r = PM_NL;
    else r = PM_NONE;
    return r;
  endfunction

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    mode_next       = mode;
    held_next       = held;
    splices_next    = splices;
    prev_next       = prev;
    line_next       = line;
    nest_line_next  = nest_line;
    stray_line_next = stray_line;
    radix_next      = radix;
    last_dig_next   = last_dig;
    n    = '0;
    sl   = '0;
    ppos = 1'b0;
    pcnt = '0;
    pm   = PM_NONE;
    wl   = '0;
    ch   = in_byte;
    go   = 1'b0;
    fb   = '0;

    if (in_end) begin
      case (mode_next)
        M_SLASH: begin
          if (!cfg.output_comments) put(n, sl, 1'b0, CH_SLASH);
          ppos = n[0]; pcnt = splices_next;
          pm = cfg.output_comments ? PM_NONE : PM_BOTH;
          if (held_next != 8'd0 && !cfg.output_comments) put(n, sl, 1'b0, CH_BSL);
        end
        M_STAR: begin
          if (com_keep(cfg, CH_STAR)) put(n, sl, 1'b0, CH_STAR);
          ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
          if (held_next != 8'd0 && com_keep(cfg, CH_BSL)) put(n, sl, 1'b0, CH_BSL);
          put(n, sl, 1'b1, {4'd0, W_UNTERM});
        end
        M_CCOM, M_CCOM_SLASH, M_LCOM: put(n, sl, 1'b1, {4'd0, W_UNTERM});
        M_NUM_SEP: put(n, sl, 1'b1, {4'd0, W_SEP_END});
        M_Q_BODY, M_Q_ESC, M_Q_BSL:
          put(n, sl, 1'b1, {4'd0, (held_next == CH_DQ) ? W_END_STR : W_END_CHR});
        default: ;
      endcase
      wl              = OUT_LINE_W'(line);
      mode_next       = M_CODE;
      held_next       = '0;
      splices_next    = '0;
      prev_next       = '0;
      line_next       = LINE_BITS'(1);
      nest_line_next  = '0;
      stray_line_next = '0;
      radix_next      = R_DEC;
      last_dig_next   = '0;
    end else begin
      go = 1'b1;
      // a byte may be handed on to at most two further modes
      for (int k = 0; k < 3; k++) begin
        if (go) begin
          go = 1'b0;
          case (mode_next)
            M_CODE: begin
              line_next = bump(line_next, ch);
              if (ch == CH_STAR) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                if (cfg.warn_nesting) mode_next = M_CODE_STAR;
              end else if (ch == CH_SQ || ch == CH_DQ) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                held_next = ch;
                mode_next = M_Q_BODY;
              end else if (ch == CH_SLASH) begin
                mode_next    = M_SLASH;
                held_next    = '0;
                splices_next = '0;
              end else if (ch == CH_ZERO) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                mode_next = M_ZERO;
              end else if (is_dig(ch)) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                radix_next    = R_DEC;
                last_dig_next = ch;
                mode_next     = M_NUM;
              end else if (ch == CH_DOT) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                mode_next = M_DOT;
              end else if (is_alpha(ch) || ch == CH_US) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                mode_next = M_IDENT;
              end else begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
              end
            end
            M_CODE_STAR: begin
              mode_next = M_CODE;
              if (ch == CH_SLASH) begin
                if (stray_line_next != line_next) begin
                  put(n, sl, 1'b1, {4'd0, W_STRAY});
                  wl = OUT_LINE_W'(line_next);
                end
                stray_line_next = line_next;
              end
              go = 1'b1;
            end
            M_SLASH: begin
              if (held_next != 8'd0) begin
                held_next = '0;
                if (ch == CH_NL) begin
                  line_next = bump(line_next, ch);
                  if (splices_next < SPL_MAX) splices_next = splices_next + SPL_W'(1);
                end else begin
                  if (!cfg.output_comments) put(n, sl, 1'b0, CH_SLASH);
                  ppos = n[0]; pcnt = splices_next;
                  pm = cfg.output_comments ? PM_NONE : PM_BOTH;
                  splices_next = '0;
                  mode_next = M_CODE;
                  if (!cfg.output_comments) put(n, sl, 1'b0, CH_BSL);
                  go = 1'b1;
                end
              end else if (ch == CH_BSL) begin
                held_next = CH_BSL;
              end else if (ch == CH_STAR) begin
                if (com_keep(cfg, CH_SLASH)) put(n, sl, 1'b0, CH_SLASH);
                ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
                splices_next = '0;
                if (com_keep(cfg, CH_STAR)) put(n, sl, 1'b0, CH_STAR);
                mode_next = M_CCOM;
              end else if (ch == CH_SLASH && cfg.line_comments_on) begin
                if (com_keep(cfg, CH_SLASH)) put(n, sl, 1'b0, CH_SLASH);
                ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
                splices_next = '0;
                if (com_keep(cfg, CH_SLASH)) put(n, sl, 1'b0, CH_SLASH);
                mode_next = M_LCOM;
                prev_next = CH_SLASH;
              end else begin
                if (!cfg.output_comments) put(n, sl, 1'b0, CH_SLASH);
                ppos = n[0]; pcnt = splices_next;
                pm = cfg.output_comments ? PM_NONE : PM_BOTH;
                splices_next = '0;
                mode_next = M_CODE;
                go = 1'b1;
              end
            end
            M_CCOM: begin
              line_next = bump(line_next, ch);
              if (ch == CH_STAR) begin
                mode_next    = M_STAR;
                splices_next = '0;
                held_next    = '0;
              end else begin
                if (com_keep(cfg, ch)) put(n, sl, 1'b0, ch);
                if (ch == CH_SLASH && cfg.warn_nesting) mode_next = M_CCOM_SLASH;
              end
            end
            M_CCOM_SLASH: begin
              mode_next = M_CCOM;
              if (ch == CH_STAR) begin
                if (nest_line_next != line_next) begin
                  put(n, sl, 1'b1, {4'd0, W_NESTED});
                  wl = OUT_LINE_W'(line_next);
                end
                nest_line_next = line_next;
              end
              go = 1'b1;
            end
            M_STAR: begin
              if (held_next != 8'd0) begin
                held_next = '0;
                if (ch == CH_NL) begin
                  line_next = bump(line_next, ch);
                  if (splices_next < SPL_MAX) splices_next = splices_next + SPL_W'(1);
                end else begin
                  if (com_keep(cfg, CH_STAR)) put(n, sl, 1'b0, CH_STAR);
                  ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
                  splices_next = '0;
                  mode_next = M_CCOM;
                  // the held backslash is plain comment text
                  if (com_keep(cfg, CH_BSL)) put(n, sl, 1'b0, CH_BSL);
                  go = 1'b1;
                end
              end else if (ch == CH_BSL) begin
                held_next = CH_BSL;
              end else if (ch == CH_SLASH) begin
                if (com_keep(cfg, CH_STAR)) put(n, sl, 1'b0, CH_STAR);
                ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
                splices_next = '0;
                if (com_keep(cfg, CH_SLASH)) put(n, sl, 1'b0, CH_SLASH);
                if (!cfg.output_comments) put(n, sl, 1'b0, CH_SP);
                mode_next = M_CODE;
              end else begin
                if (com_keep(cfg, CH_STAR)) put(n, sl, 1'b0, CH_STAR);
                ppos = n[0]; pcnt = splices_next; pm = com_pm(cfg);
                splices_next = '0;
                mode_next = M_CCOM;
                go = 1'b1;
              end
            end
            M_LCOM: begin
              line_next = bump(line_next, ch);
              if (ch == CH_NL && prev_next != CH_BSL) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                mode_next = M_CODE;
              end else begin
                if (com_keep(cfg, ch)) put(n, sl, 1'b0, ch);
              end
              prev_next = ch;
            end
            M_IDENT: begin
              if (is_alpha(ch) || is_dig(ch) || ch == CH_US) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
              end else begin
                mode_next = M_CODE;
                go = 1'b1;
              end
            end
            M_DOT: begin
              if (is_dig(ch)) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                radix_next    = R_DEC;
                last_dig_next = ch;
                mode_next     = M_NUM;
              end else begin
                mode_next = M_CODE;
                go = 1'b1;
              end
            end
            M_ZERO: begin
              if (ch == 8'h78 || ch == 8'h58) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                radix_next    = R_HEX;
                last_dig_next = ch;
                mode_next     = M_NUM;
              end else if ((ch == 8'h62 || ch == 8'h42) && cfg.binary_prefix_on) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                radix_next    = R_BIN;
                last_dig_next = ch;
                mode_next     = M_NUM;
              end else if ((ch >= 8'h30 && ch <= 8'h37) || ch == CH_SQ) begin
                radix_next    = R_OCT;
                last_dig_next = CH_ZERO;
                mode_next     = M_NUM;
                go = 1'b1;
              end else begin
                mode_next = M_CODE;
                go = 1'b1;
              end
            end
            M_NUM: begin
              if (ch == CH_SQ) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                if (valid_digit(radix_next, last_dig_next)) begin
                  mode_next = M_NUM_SEP;
                end else begin
                  put(n, sl, 1'b1, {4'd0, W_SEP_BEFORE});
                  wl = OUT_LINE_W'(line_next);
                  last_dig_next = CH_SQ;
                end
              end else if (valid_digit(radix_next, ch)) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                last_dig_next = ch;
              end else begin
                if (radix_next == R_BIN && is_dig(ch)) begin
                  put(n, sl, 1'b1, {4'd0, W_BIN_DIGIT});
                  wl = OUT_LINE_W'(line_next);
                end
                mode_next = M_CODE;
                go = 1'b1;
              end
            end
            M_NUM_SEP: begin
              if (!valid_digit(radix_next, ch)) begin
                put(n, sl, 1'b1, {4'd0, W_SEP_AFTER});
                wl = OUT_LINE_W'(line_next);
              end
              last_dig_next = ch;
              mode_next     = M_NUM;
              go = 1'b1;
            end
            M_Q_BODY, M_Q_ESC: begin
              line_next = bump(line_next, ch);
              if (held_next == CH_SQ && cfg.char_fill != 8'd0) fb = cfg.char_fill;
              else if (held_next == CH_DQ && cfg.string_fill != 8'd0) fb = cfg.string_fill;
              else fb = ch;
              if (mode_next == M_Q_ESC) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, fb);
                mode_next = (ch == CH_BSL) ? M_Q_BSL : M_Q_BODY;
              end else if (ch == held_next) begin
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
                mode_next = M_CODE;
                held_next = '0;
              end else begin
                if (!cfg.output_comments) put(n, sl, 1'b0, fb);
                if (ch == CH_BSL) begin
                  mode_next = M_Q_ESC;
                end else if (ch == CH_NL) begin
                  put(n, sl, 1'b1, {4'd0, (held_next == CH_DQ) ? W_NL_STR : W_NL_CHR});
                  wl = OUT_LINE_W'(line_next);
                end
              end
            end
            M_Q_BSL: begin
              mode_next = M_Q_BODY;
              if (ch == CH_NL) begin
                line_next = bump(line_next, ch);
                if (!cfg.output_comments) put(n, sl, 1'b0, ch);
              end else begin
                go = 1'b1;
              end
            end
            default: begin
              mode_next = M_CODE;
              go = 1'b1;
            end
          endcase
        end
      end
    end
  end

  assign job.slots = sl;
  assign job.nslot = n;
  assign job.ppos  = ppos;
  assign job.pcnt  = pcnt;
  assign job.pm    = pm;
  assign job.wline = wl;
  assign push = take && ((n != 3'd0) || ((pcnt != '0) && (pm != PM_NONE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_CODE;
      held       <= '0;
      splices    <= '0;
      prev       <= '0;
      line       <= LINE_BITS'(1);
      nest_line  <= '0;
      stray_line <= '0;
      radix      <= R_DEC;
      last_dig   <= '0;
    end else if (take) begin
      mode       <= mode_next;
      held       <= held_next;
      splices    <= splices_next;
      prev       <= prev_next;
      line       <= line_next;
      nest_line  <= nest_line_next;
      stray_line <= stray_line_next;
      radix      <= radix_next;
      last_dig   <= last_dig_next;
    end
  end

endmodule

// ===== design/cstr_fifo.sv =====
// ---------------------------------------------------------------------------
// cstr_fifo
// Short job queue between the lexer front end and the result back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cstr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cstr_pkg::job_t  din,
  input  logic            pop,
  output cstr_pkg::job_t  dout,
  output logic            full,
  output logic            empty
);
  import cstr_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "job queue written while full")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "job queue read while empty")
  `ASSERT_ALWAYS(a_count_bound, count <= (QPTR_W+1)'(QDEPTH), "job queue count out of range")

endmodule

// ===== design/cstr_back.sv =====
// ---------------------------------------------------------------------------
// cstr_back
// Result back end: expands queued jobs into one result per cycle while the output
// is not stalled, including the written-back splice pairs, into a registered output stage.
// ---------------------------------------------------------------------------
module cstr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cstr_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_bvalid,
  output logic [3:0]      out_warn,
  output logic [cstr_pkg::OUT_LINE_W-1:0] out_line,
  output logic            out_last
);
  import cstr_pkg::*;

  job_t             cur;
  logic             busy;
  logic [2:0]       sidx, sidx_next;
  logic [SPL_W-1:0] prem, prem_next;
  logic             phalf, phalf_next;
  logic [REM_W-1:0] rem, q_total;
  logic             adv;
  slot_t            s;
  logic [7:0]       r_byte;
  logic             r_bvalid;
  logic [3:0]       r_warn;
  logic [OUT_LINE_W-1:0] r_line;

  assign adv   = busy && (!out_valid || out_ready);
  assign q_pop = !q_empty && (!busy || (adv && rem == REM_W'(1)));

  always_comb begin
    case (q_job.pm)
      PM_BOTH: q_total = REM_W'(q_job.nslot) + REM_W'({q_job.pcnt, 1'b0});
      PM_NL:   q_total = REM_W'(q_job.nslot) + REM_W'(q_job.pcnt);
      default: q_total = REM_W'(q_job.nslot);
    endcase
  end

  always_comb begin
    sidx_next  = sidx;
    prem_next  = prem;
    phalf_next = phalf;
    s          = cur.slots[sidx[1:0]];
    r_byte     = '0;
    r_bvalid   = 1'b0;
    r_warn     = '0;
    r_line     = '0;
    if ((sidx >= {2'b00, cur.ppos}) && (prem != '0) && (cur.pm != PM_NONE)) begin
      r_bvalid = 1'b1;
      if (cur.pm == PM_BOTH && !phalf) begin
        r_byte     = CH_BSL;
        phalf_next = 1'b1;
      end else begin
        r_byte     = CH_NL;
        phalf_next = 1'b0;
        prem_next  = prem - SPL_W'(1);
      end
    end else begin
      sidx_next = sidx + 3'd1;
      if (s.is_warn) begin
        r_warn = s.val[3:0];
        r_line = cur.wline;
      end else begin
        r_byte   = s.val;
        r_bvalid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (adv) begin
      out_byte   <= r_byte;
      out_bvalid <= r_bvalid;
      out_warn   <= r_warn;
      out_line   <= r_line;
      out_last   <= (rem == REM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sidx      <= '0;
      prem      <= '0;
      phalf     <= 1'b0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        busy  <= 1'b1;
        sidx  <= '0;
        prem  <= q_job.pcnt;
        phalf <= 1'b0;
        rem   <= q_total;
      end else if (adv) begin
        sidx  <= sidx_next;
        prem  <= prem_next;
        phalf <= phalf_next;
        rem   <= rem - REM_W'(1);
        if (rem == REM_W'(1)) busy <= 1'b0;
      end
    end
  end

endmodule
